[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");
// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[rtl/iagc_pkg.sv]
// ----------------------------------------------------------------------------
// iagc_pkg
// Shared constants and types of the IMU activity and gesture classifier.
// ----------------------------------------------------------------------------
package iagc_pkg;

	localparam int WINDOW_DEPTH = 32;
	localparam int RING_AW      = $clog2(WINDOW_DEPTH);
	localparam int SUM_W        = 32 + $clog2(WINDOW_DEPTH);

	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 56;
	localparam int APB_AW     = 5;

	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_GESTURE = 2'd1,
		OP_DEADREC = 2'd2,
		OP_UNUSED  = 2'd3
	} opcode_t;

	localparam logic [1:0] ACT_STILL    = 2'd0;
	localparam logic [1:0] ACT_STANDING = 2'd1;
	localparam logic [1:0] ACT_RUNNING  = 2'd2;

	localparam logic [1:0] GEST_NONE  = 2'd0;
	localparam logic [1:0] GEST_CAST  = 2'd1;
	localparam logic [1:0] GEST_DRAIN = 2'd2;

	localparam logic [2:0] REG_STILL    = 3'd0;
	localparam logic [2:0] REG_STANDING = 3'd1;
	localparam logic [2:0] REG_CAST     = 3'd2;
	localparam logic [2:0] REG_DRAIN    = 3'd3;
	localparam logic [2:0] REG_COOLDOWN = 3'd4;
	localparam logic [2:0] REG_STRIDE   = 3'd5;
	localparam logic [2:0] REG_GRAVITY  = 3'd6;

	localparam logic [31:0]        RST_STILL    = 32'd3277;
	localparam logic [31:0]        RST_STANDING = 32'd52429;
	localparam logic signed [15:0] RST_CAST     = 16'sd6400;
	localparam logic signed [15:0] RST_DRAIN    = -16'sd6400;
	localparam logic [15:0]        RST_COOLDOWN = 16'd1500;
	localparam logic [15:0]        RST_STRIDE   = 16'd179;
	localparam logic [15:0]        RST_GRAVITY  = 16'd2511;

	localparam int SQRT_ITERS = 16;

endpackage

[rtl/imu_activity_gesture_classifier.sv]
// ----------------------------------------------------------------------------
// imu_activity_gesture_classifier
// Activity classifier and flick gesture latch for a three-axis IMU stream.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser carries the opcode (sample, take gesture, take
// dead-reckoning counters); s_axis_tdata carries acceleration, jerk and time.
// Output stream: one transaction per input transaction with activity class,
// gesture, step count and distance in m_axis_tdata.
// Configuration: APB registers at byte addresses 0x00..0x18, pready always high,
// to be written only while the block is idle.
// Sequence: a sample passes four times through the shared 17x17 multiplier
// (three input squares and the squared deviation), through sixteen square-root
// steps, the deviation, the ring update and classification before its result is
// loaded; take opcodes go straight to the result state.
// The next transaction is accepted only after the last result has been loaded
// into the output register.
// One transaction is in work at a time; s_axis_tready is high only when idle.
// A finished result waits in the output register while the next transaction
// is accepted; if the receiver stalls, the block holds its next result until
// the output register frees.
// Reset clears the sum, counters, gesture state and the valid bits of the
// deviation ring, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module imu_activity_gesture_classifier (
	input  logic                             clk,
	input  logic                             arst_n,
	// accel_x, accel_y, accel_z, jerk_value, time_ms
	input  logic [iagc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// opcode
	input  logic [1:0]                       s_axis_tuser,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// activity_class, gesture_taken, step_total, distance_total, zero pad
	output logic [iagc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [iagc_pkg::APB_AW-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	import iagc_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SQ    = 8'b0000_0010,
		S_ROOT  = 8'b0000_0100,
		S_DEV   = 8'b0000_1000,
		S_DSQ   = 8'b0001_0000,
		S_SUM   = 8'b0010_0000,
		S_CLASS = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	// configuration
	logic [31:0]        still_q;
	logic [31:0]        standing_q;
	logic signed [15:0] cast_q;
	logic signed [15:0] drain_q;
	logic [15:0]        cooldown_q;
	logic [15:0]        stride_q;
	logic [15:0]        gravity_q;

	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_q    <= RST_STILL;
			standing_q <= RST_STANDING;
			cast_q     <= RST_CAST;
			drain_q    <= RST_DRAIN;
			cooldown_q <= RST_COOLDOWN;
			stride_q   <= RST_STRIDE;
			gravity_q  <= RST_GRAVITY;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_STILL:    still_q    <= pwdata;
				REG_STANDING: standing_q <= pwdata;
				REG_CAST:     cast_q     <= signed'(pwdata[15:0]);
				REG_DRAIN:    drain_q    <= signed'(pwdata[15:0]);
				REG_COOLDOWN: cooldown_q <= pwdata[15:0];
				REG_STRIDE:   stride_q   <= pwdata[15:0];
				REG_GRAVITY:  gravity_q  <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_STILL:    prdata = still_q;
			REG_STANDING: prdata = standing_q;
			REG_CAST:     prdata = {16'd0, cast_q};
			REG_DRAIN:    prdata = {16'd0, drain_q};
			REG_COOLDOWN: prdata = {16'd0, cooldown_q};
			REG_STRIDE:   prdata = {16'd0, stride_q};
			REG_GRAVITY:  prdata = {16'd0, gravity_q};
			default:      prdata = 32'd0;
		endcase
	end

	// sequencer and datapath
	state_t             state_q;
	logic [3:0]         cnt_q;
	logic signed [15:0] ax_q, ay_q, az_q, jerk_q;
	logic [31:0]        now_q;
	logic [31:0]        rem_q;
	logic [31:0]        root_q;
	logic [15:0]        mag_q;
	logic [31:0]        dsq_q;
	logic [RING_AW-1:0] pos_q;
	logic [WINDOW_DEPTH-1:0] valid_q;
	logic [SUM_W-1:0]   sum_q;
	logic [1:0]         act_q;
	logic [15:0]        steps_q;
	logic [31:0]        dist_q;
	logic [1:0]         pend_q;
	logic [31:0]        last_time_q;
	logic [1:0]         res_gest_q;
	logic [15:0]        res_steps_q;
	logic [31:0]        res_dist_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic               out_valid_q;

	logic               in_fire;
	logic               out_free;
	opcode_t            op_in;
	logic signed [16:0] mul_a;
	logic signed [33:0] mul_p;
	logic [31:0]        bit_v;
	logic [31:0]        trial;
	logic signed [17:0] dev;
	logic [31:0]        old_dsq;
	logic [31:0]        ram_rdata;
	logic [SUM_W-1:0]   still_scaled;
	logic [SUM_W-1:0]   standing_scaled;
	logic [32:0]        dist_next;
	logic [31:0]        elapsed;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid & s_axis_tready;
	assign out_free      = ~out_valid_q | m_axis_tready;
	assign op_in         = opcode_t'(s_axis_tuser);

	// shared multiplier: three input squares, then the squared deviation
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    mul_a = 17'(ax_q);
			2'd1:    mul_a = 17'(ay_q);
			default: mul_a = 17'(az_q);
		endcase
		if (state_q == S_DSQ) begin
			mul_a = signed'({1'b0, mag_q});
		end
	end
	assign mul_p = mul_a * mul_a;

	// restoring square root, two bits of the radicand per step
	assign bit_v = 32'd1 << (5'd30 - {cnt_q, 1'b0});
	assign trial = root_q + bit_v;
	assign dev   = signed'({2'b00, root_q[15:0]}) - signed'({2'b00, gravity_q});

	iagc_ram #(
		.WIDTH (32),
		.DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == S_SUM),
		.waddr (pos_q),
		.wdata (dsq_q),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	assign old_dsq         = valid_q[pos_q] ? ram_rdata : 32'd0;
	assign still_scaled    = SUM_W'(still_q) * SUM_W'(WINDOW_DEPTH);
	assign standing_scaled = SUM_W'(standing_q) * SUM_W'(WINDOW_DEPTH);
	assign dist_next       = {1'b0, dist_q} + {17'd0, stride_q};
	assign elapsed         = now_q - last_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ax_q        <= '0;
			ay_q        <= '0;
			az_q        <= '0;
			jerk_q      <= '0;
			now_q       <= '0;
			rem_q       <= '0;
			root_q      <= '0;
			mag_q       <= '0;
			dsq_q       <= '0;
			pos_q       <= '0;
			valid_q     <= '0;
			sum_q       <= '0;
			act_q       <= ACT_STILL;
			steps_q     <= '0;
			dist_q      <= '0;
			pend_q      <= GEST_NONE;
			last_time_q <= '0;
			res_gest_q  <= GEST_NONE;
			res_steps_q <= '0;
			res_dist_q  <= '0;
			out_data_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						ax_q        <= signed'(s_axis_tdata[15:0]);
						ay_q        <= signed'(s_axis_tdata[31:16]);
						az_q        <= signed'(s_axis_tdata[47:32]);
						jerk_q      <= signed'(s_axis_tdata[63:48]);
						now_q       <= s_axis_tdata[95:64];
						cnt_q       <= '0;
						rem_q       <= '0;
						case (op_in)
							OP_SAMPLE: begin
								res_gest_q  <= GEST_NONE;
								res_steps_q <= '0;
								res_dist_q  <= '0;
								state_q     <= S_SQ;
							end
							OP_GESTURE: begin
								res_gest_q  <= pend_q;
								res_steps_q <= '0;
								res_dist_q  <= '0;
								pend_q      <= GEST_NONE;
								state_q     <= S_DONE;
							end
							OP_DEADREC: begin
								res_gest_q  <= GEST_NONE;
								res_steps_q <= steps_q;
								res_dist_q  <= dist_q;
								steps_q     <= '0;
								dist_q      <= '0;
								state_q     <= S_DONE;
							end
							default: begin
								res_gest_q  <= GEST_NONE;
								res_steps_q <= '0;
								res_dist_q  <= '0;
								state_q     <= S_DONE;
							end
						endcase
					end
				end
				S_SQ: begin
					rem_q <= rem_q + mul_p[31:0];
					if (cnt_q == 4'd2) begin
						cnt_q   <= '0;
						root_q  <= '0;
						state_q <= S_ROOT;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_ROOT: begin
					if (rem_q >= trial) begin
						rem_q  <= rem_q - trial;
						root_q <= (root_q >> 1) + bit_v;
					end else begin
						root_q <= root_q >> 1;
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(SQRT_ITERS - 1)) begin
						state_q <= S_DEV;
					end
				end
				S_DEV: begin
					mag_q   <= dev[17] ? 16'(-dev) : dev[15:0];
					state_q <= S_DSQ;
				end
				S_DSQ: begin
					dsq_q   <= mul_p[31:0];
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q          <= sum_q - SUM_W'(old_dsq) + SUM_W'(dsq_q);
					valid_q[pos_q] <= 1'b1;
					pos_q          <= (pos_q == RING_AW'(WINDOW_DEPTH - 1)) ? '0
					                  : pos_q + RING_AW'(1);
					state_q        <= S_CLASS;
				end
				S_CLASS: begin
					if (sum_q < still_scaled) begin
						act_q <= ACT_STILL;
					end else if (sum_q < standing_scaled) begin
						act_q <= ACT_STANDING;
					end else begin
						act_q <= ACT_RUNNING;
						if (steps_q != 16'hFFFF) begin
							steps_q <= steps_q + 16'd1;
						end
						dist_q <= dist_next[32] ? 32'hFFFF_FFFF : dist_next[31:0];
					end
					if (elapsed > {16'd0, cooldown_q}) begin
						if (jerk_q > cast_q) begin
							pend_q      <= GEST_CAST;
							last_time_q <= now_q;
						end else if (jerk_q < drain_q) begin
							pend_q      <= GEST_DRAIN;
							last_time_q <= now_q;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_data_q  <= {4'd0, res_dist_q, res_steps_q, res_gest_q, act_q};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tdata  = out_data_q;
	assign m_axis_tvalid = out_valid_q;

	`ASSERT_AT(a_one_in_flight, clk, arst_n, in_fire |=> !s_axis_tready)
	`ASSERT_NEVER(a_act_code, clk, arst_n, m_axis_tvalid && (m_axis_tdata[1:0] == 2'd3))
	`ASSERT_NEVER(a_gest_vs_deadrec, clk, arst_n,
		m_axis_tvalid && (m_axis_tdata[3:2] != GEST_NONE) && (m_axis_tdata[51:4] != '0))
	`ASSERT_AT(a_root_bounded, clk, arst_n, (state_q == S_DEV) |-> (root_q[31:16] == 16'd0))

endmodule

[rtl/iagc_ram.sv]
// ----------------------------------------------------------------------------
// iagc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iagc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
